@@ sv/scatter_cosine_sampler_macros.svh @@
// ============================================================================
// Scatter cosine sampler assertion macros
// Shared property wrappers; clocked on clk and disabled while arst_n is low.
// ============================================================================
`ifndef SCATTER_COSINE_SAMPLER_MACROS_SVH
`define SCATTER_COSINE_SAMPLER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scatter cosine sampler check failed");

// Consequent holds in the cycle after the antecedent.
`define SCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scatter cosine sampler check failed");

`endif

@@ sv/scs_pkg.sv @@
// ============================================================================
// Scatter cosine sampler package
// Shared widths, register indexes and the divider pipeline word.
// ============================================================================
`timescale 1ns / 1ps

package scs_pkg;

	localparam int REM_W = 81;
	localparam int E2_W  = 63;
	localparam int QUO_W = 18;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_G_FORWARD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_G_BACKWARD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIX_WEIGHT = 3'd3;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [E2_W-1:0]  e2;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             sat;
		logic             ez;
		logic             lobe;
	} div_word_t;

endpackage

@@ sv/scs_poly.sv @@
// ============================================================================
// Scatter cosine sampler numerator and denominator
// Evaluates the inverse CDF rational and prepares the scaled dividend.
// ============================================================================
`timescale 1ns / 1ps

module scs_poly #(
	parameter int FRACTION_BITS = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic signed [15:0]  g_in,
	input  logic signed [16:0]  u_in,
	input  logic                lobe_in,
	output logic                valid_out,
	output scs_pkg::div_word_t  d_out
);

	localparam int UP   = (FRACTION_BITS > 15) ? FRACTION_BITS - 15 : 0;
	localparam int DN   = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 0;
	localparam int NN_W = scs_pkg::REM_W + UP;

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic lobe_s2, lobe_s3, lobe_s4, lobe_s5, lobe_s6;

	logic signed [15:0] g_s2;
	logic signed [16:0] u_s2;
	logic signed [31:0] g2_s2;
	logic signed [32:0] gu_s2;

	logic signed [32:0] p_c;
	logic signed [33:0] w_c;
	logic signed [32:0] k_c;
	logic signed [33:0] e_c;

	logic signed [50:0] m_s3;
	logic signed [48:0] c_s3;
	logic [62:0]        e2_s3;
	logic               ez_s3;
	logic [31:0]        p_s3;

	logic signed [59:0] ph_s4;
	logic [55:0]        pl_s4;
	logic signed [48:0] c_s4;
	logic [62:0]        e2_s4;
	logic               ez_s4;

	logic signed [81:0] num_s5;
	logic [62:0]        e2_s5;
	logic               ez_s5;

	logic [80:0]        nabs_s6;
	logic               neg_s6;
	logic [62:0]        e2_s6;
	logic               ez_s6;

	logic [NN_W-1:0]    nn_c;
	logic [NN_W-1:0]    lim_c;
	scs_pkg::div_word_t d_s7;

	assign p_c = 33'sd1073741824 + 33'(g2_s2);
	assign w_c = 34'sd2147483648 + 34'(gu_s2);
	assign k_c = 33'sd3221225472 - 33'(g2_s2);
	assign e_c = 34'sd1073741824 + 34'(gu_s2);

	assign nn_c  = (NN_W'(nabs_s6) << UP) >> DN;
	assign lim_c = NN_W'(e2_s6) << 18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= valid_in;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2    <= g_in;
			u_s2    <= u_in;
			g2_s2   <= g_in * g_in;
			gu_s2   <= g_in * u_in;
			lobe_s2 <= lobe_in;

			m_s3    <= u_s2 * w_c;
			c_s3    <= g_s2 * k_c;
			e2_s3   <= e_c[31:0] * e_c[31:0];
			ez_s3   <= (e_c <= 34'sd0);
			p_s3    <= p_c[31:0];
			lobe_s3 <= lobe_s2;

			ph_s4   <= $signed({1'b0, p_s3}) * $signed(m_s3[50:24]);
			pl_s4   <= p_s3 * m_s3[23:0];
			c_s4    <= c_s3;
			e2_s4   <= e2_s3;
			ez_s4   <= ez_s3;
			lobe_s4 <= lobe_s3;

			num_s5  <= (82'(ph_s4) <<< 24) + $signed({26'd0, pl_s4}) + (82'(c_s4) <<< 30);
			e2_s5   <= e2_s4;
			ez_s5   <= ez_s4;
			lobe_s5 <= lobe_s4;

			neg_s6  <= num_s5[81];
			nabs_s6 <= num_s5[81] ? 81'(-num_s5) : 81'(num_s5);
			e2_s6   <= e2_s5;
			ez_s6   <= ez_s5;
			lobe_s6 <= lobe_s5;

			d_s7.rem  <= nn_c[scs_pkg::REM_W-1:0];
			d_s7.e2   <= e2_s6;
			d_s7.quo  <= '0;
			d_s7.neg  <= neg_s6;
			d_s7.sat  <= (nn_c >= lim_c);
			d_s7.ez   <= ez_s6;
			d_s7.lobe <= lobe_s6;
		end
	end

	assign valid_out = v_s7;
	assign d_out     = d_s7;

endmodule

@@ sv/scs_div_step.sv @@
// ============================================================================
// Scatter cosine sampler divider step
// One restoring division step that settles one quotient bit.
// ============================================================================
`timescale 1ns / 1ps

module scs_div_step #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  scs_pkg::div_word_t d_in,
	output logic               valid_out,
	output scs_pkg::div_word_t d_out
);

	logic [scs_pkg::REM_W-1:0] trial_c;
	scs_pkg::div_word_t        next_c;
	logic                      v_s1;
	scs_pkg::div_word_t        d_s1;

	assign trial_c = scs_pkg::REM_W'(d_in.e2) << SHIFT;

	always_comb begin
		next_c = d_in;
		if (d_in.rem >= trial_c) begin
			next_c.rem        = d_in.rem - trial_c;
			next_c.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= next_c;
		end
	end

	assign valid_out = v_s1;
	assign d_out     = d_s1;

endmodule

@@ sv/scatter_cosine_sampler.sv @@
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits, so a stall drops and repeats nothing.
// The pipeline is one input stage, six polynomial stages, the 18-stage
// restoring divider with one quotient bit a stage, and one output stage.
// Reset clears all valid bits and sets the registers to single lobe, zero
// asymmetry and full forward weight; configuration writes are taken every cycle.
// ============================================================================
// Scatter cosine sampler
// Henyey-Greenstein inverse CDF sampling of the scattering cosine, single or two-term.
// ============================================================================
`timescale 1ns / 1ps

module scatter_cosine_sampler #(
	parameter int FRACTION_BITS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [scs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [16:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [15:0]                        q_uniform,
	input  logic [15:0]                        select_uniform,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 cosine,
	output logic                               lobe_used
);

	localparam int HI_LIM  = (FRACTION_BITS >= 15) ? 32767 : (1 << FRACTION_BITS) - 1;
	localparam int NEG_MAG = (FRACTION_BITS >= 15) ? 32768 : (1 << FRACTION_BITS);
	localparam int NSTEP   = scs_pkg::QUO_W;

	logic               phase_mode_q;
	logic signed [15:0] g_forward_q;
	logic signed [15:0] g_backward_q;
	logic [16:0]        mix_weight_q;

	logic               en;
	logic               sel_c;
	logic               v_s1;
	logic signed [15:0] g_s1;
	logic signed [16:0] u_s1;
	logic               lobe_s1;

	logic               dv [0:NSTEP];
	scs_pkg::div_word_t dw [0:NSTEP];

	logic [18:0]        tplus_c;
	logic [17:0]        mag_c;
	logic signed [17:0] val_c;

	logic               v_s26;
	logic signed [15:0] cos_s26;
	logic               lobe_s26;

	assign cfg_ready = 1'b1;
	assign en        = !v_s26 || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_mode_q <= 1'b0;
			g_forward_q  <= '0;
			g_backward_q <= '0;
			mix_weight_q <= 17'h10000;
		end else if (cfg_valid) begin
			case (cfg_index)
				scs_pkg::CFG_PHASE_MODE: phase_mode_q <= cfg_data[0];
				scs_pkg::CFG_G_FORWARD:  g_forward_q  <= cfg_data[15:0];
				scs_pkg::CFG_G_BACKWARD: g_backward_q <= cfg_data[15:0];
				scs_pkg::CFG_MIX_WEIGHT: mix_weight_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign sel_c = phase_mode_q && ({1'b0, select_uniform} >= mix_weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1    <= sel_c ? g_backward_q : g_forward_q;
			u_s1    <= 17'sd32768 - $signed({1'b0, q_uniform});
			lobe_s1 <= sel_c;
		end
	end

	scs_poly #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (v_s1),
		.g_in     (g_s1),
		.u_in     (u_s1),
		.lobe_in  (lobe_s1),
		.valid_out(dv[0]),
		.d_out    (dw[0])
	);

	for (genvar i = 0; i < NSTEP; i++) begin : g_div
		scs_div_step #(
			.SHIFT(NSTEP - 1 - i)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (dv[i]),
			.d_in     (dw[i]),
			.valid_out(dv[i+1]),
			.d_out    (dw[i+1])
		);
	end

	assign tplus_c = {1'b0, dw[NSTEP].quo} + 19'd1;
	assign mag_c   = tplus_c[18:1];

	always_comb begin
		if (dw[NSTEP].ez) begin
			val_c = -18'(NEG_MAG);
		end else if (dw[NSTEP].neg) begin
			if (dw[NSTEP].sat || mag_c > 18'(NEG_MAG)) begin
				val_c = -18'(NEG_MAG);
			end else begin
				val_c = -$signed(mag_c);
			end
		end else begin
			if (dw[NSTEP].sat || mag_c > 18'(HI_LIM)) begin
				val_c = 18'(HI_LIM);
			end else begin
				val_c = $signed(mag_c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (en) begin
			v_s26 <= dv[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s26  <= val_c[15:0];
			lobe_s26 <= dw[NSTEP].lobe;
		end
	end

	assign out_valid = v_s26;
	assign cosine    = cos_s26;
	assign lobe_used = lobe_s26;

endmodule

@@ sv/scs_checker.sv @@
// ============================================================================
// Scatter cosine sampler port checker
// Watches the top-level ports for handshake and flow-control slips.
// ============================================================================
`timescale 1ns / 1ps
`include "scatter_cosine_sampler_macros.svh"

module scs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] cosine,
	input logic               lobe_used
);

	`SCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cosine) && $stable(lobe_used))
	`SCS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
	`SCS_ASSERT_NOW(a_ready_when_drained, out_ready, in_ready)
	`SCS_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)

endmodule

bind scatter_cosine_sampler scs_checker u_scs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_ready(cfg_ready),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cosine   (cosine),
	.lobe_used(lobe_used)
);

@@ bench/testbench.sv @@
// ============================================================================
// Scatter cosine sampler testbench
// Drives random and directed words through the sampler under several register
// settings, predicts each cosine exactly and compares every output word.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [15:0] q;
		logic [15:0] sel;
	} draw_t;

	typedef struct {
		logic signed [15:0] cosv;
		logic               lobe;
	} sample_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [scs_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [16:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [15:0] q_uniform;
	logic [15:0] select_uniform;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] cosine;
	logic lobe_used;

	draw_t   pending_draws[$];
	sample_t expected_samples[$];
	int      mismatches = 0;
	bit      sender_hold = 1'b1;

	logic               two_term;
	logic signed [15:0] g_fwd;
	logic signed [15:0] g_bwd;
	logic [16:0]        alpha;

	scatter_cosine_sampler u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.q_uniform(q_uniform), .select_uniform(select_uniform),
		.out_valid(out_valid), .out_ready(out_ready),
		.cosine(cosine), .lobe_used(lobe_used)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic sample_t hg_cosine(logic [15:0] q, logic [15:0] sel);
		sample_t s;
		longint gv, u, e, v;
		logic signed [199:0] num, t, e2, quo;
		logic neg;
		s.lobe = two_term && ({1'b0, sel} >= alpha);
		gv = s.lobe ? longint'(g_bwd) : longint'(g_fwd);
		u = 64'sd32768 - longint'(q);
		e = (64'sd1 <<< 30) + gv * u;
		if (e <= 0) begin
			v = -32768;
		end else begin
			num = u;
			num = num <<< 61;
			t = gv * (u * u + (64'sd3 <<< 30));
			num = num + (t <<< 30);
			t = 2 * gv * gv * u;
			num = num + (t <<< 30);
			t = gv * gv * gv;
			t = t * (u * u - (64'sd1 <<< 30));
			num = num + t;
			neg = num < 0;
			if (neg) begin
				num = -num;
			end
			e2 = e;
			e2 = e2 * e2;
			quo = (num + e2) / (e2 <<< 1);
			if (quo > (200'sd1 <<< 33)) begin
				quo = 200'sd1 <<< 33;
			end
			v = neg ? -longint'(quo) : longint'(quo);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
		end
		s.cosv = v[15:0];
		return s;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			q_uniform <= '0;
			select_uniform <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sender_hold || pending_draws.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				q_uniform <= pending_draws[0].q;
				select_uniform <= pending_draws[0].sel;
				void'(pending_draws.pop_front());
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Receiver: the stall mode is redrawn from a free-running counter, including stall-free runs.
	int stall_cycle = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			if (stall_cycle % 256 == 0) begin
				stall_mode <= $urandom_range(0, 3);
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((stall_cycle / 5) % 2 == 0);
			endcase
		end
	end

	// Register shadow, prediction on acceptance and checking of output words.
	always @(posedge clk or negedge arst_n) begin
		sample_t exp_s;
		if (!arst_n) begin
			two_term <= 1'b0;
			g_fwd <= '0;
			g_bwd <= '0;
			alpha <= 17'd65536;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					scs_pkg::CFG_PHASE_MODE: two_term <= cfg_data[0];
					scs_pkg::CFG_G_FORWARD:  g_fwd <= cfg_data[15:0];
					scs_pkg::CFG_G_BACKWARD: g_bwd <= cfg_data[15:0];
					scs_pkg::CFG_MIX_WEIGHT: alpha <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_samples.push_back(hg_cosine(q_uniform, select_uniform));
			end
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected output word: cos %0d lobe %0d",
							cosine, lobe_used);
					end
				end else begin
					exp_s = expected_samples.pop_front();
					if (exp_s.cosv !== cosine || exp_s.lobe !== lobe_used) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: cos exp %0d got %0d, lobe exp %0d got %0d",
								exp_s.cosv, cosine, exp_s.lobe, lobe_used);
						end
					end
				end
			end
		end
	end

	task automatic wait_drained();
		sender_hold = 1'b0;
		do @(posedge clk);
		while (pending_draws.size() != 0 || in_valid || expected_samples.size() != 0);
		sender_hold = 1'b1;
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [scs_pkg::CFG_INDEX_W-1:0] idx, logic [16:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_draw(logic [15:0] q, logic [15:0] sel);
		draw_t d;
		d.q = q;
		d.sel = sel;
		pending_draws.push_back(d);
	endtask

	task automatic run_phase(logic mode, logic [15:0] gf, logic [15:0] gb,
		logic [16:0] mix, int count);
		sender_hold = 1'b1;
		wait_drained();
		write_reg(scs_pkg::CFG_PHASE_MODE, {16'($urandom), mode});
		write_reg(scs_pkg::CFG_G_FORWARD, {1'($urandom), gf});
		write_reg(scs_pkg::CFG_G_BACKWARD, {1'($urandom), gb});
		write_reg(scs_pkg::CFG_MIX_WEIGHT, mix);
		@(posedge clk);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: add_draw(16'($urandom_range(0, 3)), 16'($urandom));
				1: add_draw(16'($urandom_range(65532, 65535)), 16'($urandom));
				2: add_draw(16'($urandom), mix[15:0] + 16'($urandom_range(0, 2)) - 16'd1);
				default: add_draw(16'($urandom), 16'($urandom));
			endcase
		end
		sender_hold = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero asymmetry, isotropic result, extremes of q.
		add_draw(16'd0, 16'd0);
		add_draw(16'd1, 16'hFFFF);
		add_draw(16'd32767, 16'd0);
		add_draw(16'd32768, 16'hFFFF);
		add_draw(16'd65535, 16'h5555);
		add_draw(16'hAAAA, 16'hAAAA);
		sender_hold = 1'b0;

		// Registers outside the list must be ignored.
		sender_hold = 1'b1;
		wait_drained();
		write_reg(3'd4, 17'h1FFFF);
		write_reg(3'd7, 17'h1FFFF);
		add_draw(16'd0, 16'd0);
		add_draw(16'd40000, 16'd65535);
		add_draw(16'd12345, 16'd54321);
		sender_hold = 1'b0;

		// Asymmetry of minus one, with q = 0 where the denominator vanishes.
		sender_hold = 1'b1;
		wait_drained();
		write_reg(scs_pkg::CFG_G_FORWARD, 17'h08000);
		add_draw(16'd0, 16'd0);
		add_draw(16'd1, 16'd0);
		add_draw(16'd65535, 16'd0);
		add_draw(16'd32768, 16'd0);
		sender_hold = 1'b0;

		// Two-term selection around the mix boundary.
		sender_hold = 1'b1;
		wait_drained();
		write_reg(scs_pkg::CFG_PHASE_MODE, 17'd1);
		write_reg(scs_pkg::CFG_G_FORWARD, 17'd32767);
		write_reg(scs_pkg::CFG_G_BACKWARD, 17'h18001);
		write_reg(scs_pkg::CFG_MIX_WEIGHT, 17'd1000);
		add_draw(16'd0, 16'd999);
		add_draw(16'd0, 16'd1000);
		add_draw(16'd65535, 16'd999);
		add_draw(16'd65535, 16'd1000);
		add_draw(16'd32768, 16'd0);
		add_draw(16'd1, 16'd65535);
		sender_hold = 1'b0;

		run_phase(1'b0, 16'd32767, 16'd0, 17'd65536, 200);
		run_phase(1'b0, -16'sd32767, 16'd12000, 17'd0, 200);
		run_phase(1'b0, 16'h8000, 16'd5, 17'd300, 150);
		run_phase(1'b1, 16'd29000, -16'sd16000, 17'd65536, 200);
		run_phase(1'b1, 16'd0, 16'h8000, 17'd0, 200);
		run_phase(1'b1, 16'd26214, -16'sd9830, 17'd65535, 150);
		run_phase(1'b1, 16'd32767, -16'sd32767, 17'd32768, 200);
		for (int p = 0; p < 3; p++) begin
			run_phase(1'($urandom), 16'($urandom), 16'($urandom),
				17'($urandom_range(0, 65536)), 200);
		end

		sender_hold = 1'b1;
		wait_drained();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
